// ----- rtl/mma_pkg.sv -----
package mma_pkg;

	// Window and channel count
	localparam int WINDOW_LENGTH = 10;
	localparam int NUM_CHANNELS  = 6;

	// Field widths
	localparam int CHAN_W   = 3;
	localparam int SAMPLE_W = 16;
	localparam int OUT_W    = 20;

	// Stream bus widths, rounded up to whole bytes
	localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

	// Exact running sum width
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH);

	// Sample store geometry
	localparam int MEM_DEPTH = NUM_CHANNELS * WINDOW_LENGTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int POS_W     = $clog2(WINDOW_LENGTH);

	// Running sum handed to the averaging pipeline
	typedef struct packed {
		logic [CHAN_W-1:0]       channel;
		logic signed [SUM_W-1:0] sum;
	} sum_word_t;

	// Finished result
	typedef struct packed {
		logic signed [OUT_W-1:0] average_q4;
		logic signed [OUT_W-1:0] window_sum;
		logic [CHAN_W-1:0]       channel;
	} res_word_t;

endpackage

// ----- rtl/mma_avg.sv -----
module mma_avg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mma_pkg::sum_word_t in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output mma_pkg::res_word_t out_word
);
	import mma_pkg::*;

	// |sum| * 16, divided by the window through a reciprocal multiply
	localparam int A_W       = SUM_W + 4;
	localparam int M_W       = A_W + 1;
	localparam int PROD_W    = A_W + M_W;
	localparam int DIV_SHIFT = A_W + $clog2(WINDOW_LENGTH);
	localparam longint unsigned DIV_MULT =
		((longint'(1) << DIV_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
	localparam logic [M_W-1:0] MULT = M_W'(DIV_MULT);
	localparam int WIDE_W    = A_W + 1;
	localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
	localparam int OUT_MIN   = -(1 << (OUT_W - 1));

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > WIDE_W'(OUT_MAX)) begin
			r = OUT_W'(OUT_MAX);
		end else if (v < WIDE_W'(OUT_MIN)) begin
			r = OUT_W'(OUT_MIN);
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

	logic                    v_s2, v_s3, v_s4, vld_q;
	logic                    rdy_s3, rdy_s4, rdy_out;
	logic [CHAN_W-1:0]       ch_s2, ch_s3, ch_s4;
	logic signed [SUM_W-1:0] sum_s2, sum_s3, sum_s4;
	logic [SUM_W-1:0]        mag_s3;
	logic                    neg_s3, neg_s4;
	logic [PROD_W-1:0]       prod_s4;
	logic [A_W-1:0]          quot;
	logic signed [WIDE_W-1:0] avg_wide;
	res_word_t               res_q;

	// Stage readiness: a stage takes a word when empty or draining
	assign rdy_out  = !vld_q || out_ready;
	assign rdy_s4   = !v_s4 || rdy_out;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = !v_s2 || rdy_s3;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			if (in_ready) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_out) vld_q <= v_s4;
		end
	end

	// Capture the sum
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s2  <= in_word.channel;
			sum_s2 <= in_word.sum;
		end
	end

	// Take the magnitude
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			ch_s3  <= ch_s2;
			sum_s3 <= sum_s2;
			neg_s3 <= sum_s2[SUM_W-1];
			mag_s3 <= sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);
		end
	end

	// Multiply by the reciprocal of the window
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			ch_s4   <= ch_s3;
			sum_s4  <= sum_s3;
			neg_s4  <= neg_s3;
			prod_s4 <= PROD_W'({mag_s3, 4'b0000}) * PROD_W'(MULT);
		end
	end

	// Drop the fraction, restore the sign, saturate
	assign quot     = A_W'(prod_s4[PROD_W-1:DIV_SHIFT]);
	assign avg_wide = neg_s4 ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

	always_ff @(posedge clk) begin
		if (rdy_out && v_s4) begin
			res_q.channel    <= ch_s4;
			res_q.window_sum <= sat_out(WIDE_W'(sum_s4));
			res_q.average_q4 <= sat_out(avg_wide);
		end
	end

	assign out_valid = vld_q;
	assign out_word  = res_q;

endmodule

// ----- rtl/multichannel_moving_average.sv -----
// Six-channel moving average over the last ten samples of each channel. A word on the
// slave side carries the sample in s_tdata and its channel in s_tuser; one result word
// per input word appears on the master side, in input order, with the echoed channel,
// the exact window sum and the average in signed Q.4 (truncated toward zero), both
// saturated to 20 bits. The block takes one word per cycle while s_tready is high (the
// pipeline stalls while m_tready is low), any mix of channels. A word first reads the
// sample store, which holds every channel's ring in one synchronous memory read and
// rewritten at the same slot as the word enters; the running sum is then updated from
// the stage-one registers, and the registered reciprocal multiply stages form the
// average. Channels six and seven change no state and return zero sum and average.
// Reset leaves every stored sample at zero through per-entry valid bits, so no
// clearing pass is needed.
module multichannel_moving_average (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mma_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] sample
	input  logic [mma_pkg::CHAN_W-1:0]     s_tuser,   // [2:0] channel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mma_pkg::M_TDATA_W-1:0]  m_tdata,   // [19:0] window_sum, [39:20] average_q4
	output logic [mma_pkg::CHAN_W-1:0]     m_tuser    // [2:0] channel_out
);
	import mma_pkg::*;

	logic [SAMPLE_W-1:0]     mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]    mem_vld_q;
	logic [POS_W-1:0]        pos_q [NUM_CHANNELS];
	logic signed [SUM_W-1:0] sums_q [NUM_CHANNELS];

	logic                    s_acc, in_rng;
	logic [CH_W-1:0]         ch_idx;
	logic [POS_W-1:0]        pos;
	logic [ADDR_W-1:0]       addr;

	logic                    v_s1, rng_s1, old_vld_s1;
	logic [CHAN_W-1:0]       ch_s1;
	logic [CH_W-1:0]         ch_idx_s1;
	logic signed [SAMPLE_W-1:0] sample_s1, old_s1;
	logic signed [SUM_W-1:0] old_ext, sum_next;

	logic                    avg_rdy, res_vld;
	sum_word_t               avg_in;
	res_word_t               res;

	// Address the ring slot of the incoming word
	assign s_acc  = s_tvalid && s_tready;
	assign in_rng = int'(s_tuser) < NUM_CHANNELS;
	assign ch_idx = CH_W'(s_tuser);
	assign pos    = pos_q[ch_idx];
	assign addr   = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_LENGTH) + ADDR_W'(pos);

	assign s_tready = !v_s1 || avg_rdy;

	// Read the oldest sample and write the new one in its place
	always_ff @(posedge clk) begin
		if (s_acc) begin
			old_s1 <= mem[addr];
			if (in_rng) mem[addr] <= s_tdata[SAMPLE_W-1:0];
		end
	end

	// Hold the stage-one word
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ch_s1      <= s_tuser;
			ch_idx_s1  <= ch_idx;
			sample_s1  <= s_tdata[SAMPLE_W-1:0];
			rng_s1     <= in_rng;
			old_vld_s1 <= mem_vld_q[addr];
		end
	end

	// Control state: valid bits, ring positions, running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			mem_vld_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				pos_q[i]  <= '0;
				sums_q[i] <= '0;
			end
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (s_acc && in_rng) begin
				mem_vld_q[addr] <= 1'b1;
				pos_q[ch_idx]   <= (int'(pos) == WINDOW_LENGTH - 1) ? '0 : pos + 1'b1;
			end
			if (v_s1 && avg_rdy && rng_s1) sums_q[ch_idx_s1] <= sum_next;
		end
	end

	// Update the running sum: drop the oldest sample, add the new one
	assign old_ext  = old_vld_s1 ? SUM_W'(old_s1) : '0;
	assign sum_next = sums_q[ch_idx_s1] - old_ext + SUM_W'(sample_s1);

	assign avg_in.channel = ch_s1;
	assign avg_in.sum     = rng_s1 ? sum_next : '0;

	mma_avg u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (avg_rdy),
		.in_word   (avg_in),
		.out_valid (res_vld),
		.out_ready (m_tready),
		.out_word  (res)
	);

	assign m_tvalid = res_vld;
	assign m_tuser  = res.channel;
	assign m_tdata  = M_TDATA_W'({res.average_q4, res.window_sum});

	// Ring position stays inside the window
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && in_rng |-> int'(pos) < WINDOW_LENGTH)
		else $error("ring position out of window");

	// An accepted word always lands in stage one
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> v_s1)
		else $error("accepted word lost before stage one");

	// Unused channels give zero results
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && int'(m_tuser) >= NUM_CHANNELS |-> m_tdata == '0)
		else $error("nonzero result for unused channel");

	// Average carries the sign of the sum
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_W-1] == m_tdata[2*OUT_W-1])
		else $error("average sign differs from window sum");

endmodule
